// ===== rtl/multi_tap_text_entry_top_macros.svh =====
// ---------------------------------------------------------------------------
// multi_tap_text_entry_top_macros.svh
// Assertion macros for the multi-tap text entry block; they expand to
// nothing when SYNTHESIS is defined. clk and rst_n come from the using scope.
// ---------------------------------------------------------------------------
`ifndef MULTI_TAP_TEXT_ENTRY_TOP_MACROS_SVH
`define MULTI_TAP_TEXT_ENTRY_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MTTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MTTE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MTTE_ASSERT_IMP(label, ante, cons, msg)
`define MTTE_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/mtte_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mtte_pkg
// Types, codes and symbol tables shared by the multi-tap text entry block.
// ---------------------------------------------------------------------------
package mtte_pkg;

    // sizes and reset values
    localparam int BUFFER_CHARS_DEF = 32;
    localparam int COMMIT_MAX       = 32;
    localparam int COUNT_W          = 6;
    localparam int TICK_W           = 16;
    localparam int CFG_DATA_W       = 16;
    localparam int REG_INDEX_W      = 1;

    localparam logic [COUNT_W-1:0] MAX_LENGTH_RST = 6'd10;
    localparam logic [TICK_W-1:0]  TIMEOUT_RST    = 16'd1000;
    localparam logic [TICK_W-1:0]  TICK_SAT       = 16'hFFFF;

    // characters
    localparam logic [7:0] EMPTY_CHAR = 8'hFF;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // register indexes
    localparam logic [REG_INDEX_W-1:0] REG_MAX_LENGTH = 1'd0;
    localparam logic [REG_INDEX_W-1:0] REG_TIMEOUT    = 1'd1;

    // request opcodes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // key codes
    localparam logic [3:0] KEY_ZERO   = 4'd0;
    localparam logic [3:0] KEY_NINE   = 4'd9;
    localparam logic [3:0] KEY_MODE   = 4'd10;
    localparam logic [3:0] KEY_SPACE  = 4'd11;
    localparam logic [3:0] KEY_DELETE = 4'd12;
    localparam logic [3:0] KEY_ENTER  = 4'd13;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_CHAR   = 1'b1;

    // payloads
    typedef struct packed {
        logic       opcode;
        logic [3:0] key_code;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         char_value;
        logic [4:0]         position;
        logic [COUNT_W-1:0] length;
        logic               alpha_mode;
        logic               pending;
        logic               beep;
        logic               last;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic take_item;
        logic exec;
        logic rd_stat;
        logic rd_char;
        logic emit_stat;
        logic emit_char;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_commit;
        logic final_char;
        logic out_free;
    } dp_sts_t;

    // symbol idx of each key group; groups of letters are contiguous ascii
    function automatic logic [7:0] grp_sym(input logic [3:0] key, input logic [1:0] idx);
        logic [7:0] sym;
        sym = 8'h00;
        case (key)
            4'd1:    sym = (idx == 2'd0) ? 8'h2E : 8'h2D;
            4'd2:    sym = 8'h41 + {6'd0, idx};
            4'd3:    sym = 8'h44 + {6'd0, idx};
            4'd4:    sym = 8'h47 + {6'd0, idx};
            4'd5:    sym = 8'h4A + {6'd0, idx};
            4'd6:    sym = 8'h4D + {6'd0, idx};
            4'd7:    sym = 8'h50 + {6'd0, idx};
            4'd8:    sym = 8'h54 + {6'd0, idx};
            4'd9:    sym = 8'h57 + {6'd0, idx};
            default: sym = 8'h00;
        endcase
        return sym;
    endfunction

    // number of symbols in each key group
    function automatic logic [2:0] grp_size(input logic [3:0] key);
        logic [2:0] n;
        n = 3'd0;
        case (key)
            4'd1:                                    n = 3'd2;
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8:      n = 3'd3;
            4'd7, 4'd9:                              n = 3'd4;
            default:                                 n = 3'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mtte_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mtte_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mtte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mtte_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mtte_ctrl
// Sequencer: takes one request, runs it through the datapath, and steps
// through the commit stream one character at a time.
// ---------------------------------------------------------------------------
module mtte_ctrl
    import mtte_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    output dp_cmd_t      cmd,
    input  wire dp_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_STAT,
        S_CRD,
        S_CEMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = sts.is_commit ? S_CRD : S_RD;
            end
            S_RD:
            begin
                state_next = S_STAT;
            end
            S_STAT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CRD:
            begin
                state_next = S_CEMIT;
            end
            S_CEMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.final_char ? S_IDLE : S_CRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign item_ready = ready_reg;

    // command decode
    always_comb
    begin
        cmd           = '0;
        cmd.take_item = ready_reg && item_valid;
        cmd.exec      = (state_reg == S_EXEC);
        cmd.rd_stat   = (state_reg == S_RD);
        cmd.rd_char   = (state_reg == S_CRD);
        cmd.emit_stat = (state_reg == S_STAT) && sts.out_free;
        cmd.emit_char = (state_reg == S_CEMIT) && sts.out_free;
    end

endmodule
`default_nettype wire

// ===== rtl/mtte_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mtte_dp
// Datapath: entry state, configuration registers, text buffer RAM and the
// result register.
// ---------------------------------------------------------------------------
module mtte_dp
    import mtte_pkg::*;
#(
    parameter int BUFFER_CHARS = BUFFER_CHARS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire in_item_t                item,
    input  wire logic                    wr_en,
    input  wire logic [REG_INDEX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0]   wr_data,
    input  wire dp_cmd_t                 cmd,
    output dp_sts_t                      sts,
    output logic                         result_valid,
    input  wire logic                    result_ready,
    output out_item_t                    result
);

    localparam int CAP = (BUFFER_CHARS < COMMIT_MAX) ? BUFFER_CHARS : COMMIT_MAX;
    localparam int AW  = (BUFFER_CHARS > 1) ? $clog2(BUFFER_CHARS) : 1;
    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAP);

    // configuration
    logic [COUNT_W-1:0] max_length_reg;
    logic [TICK_W-1:0]  timeout_reg;

    // current request
    logic       op_reg;
    logic [3:0] key_reg;

    // entry state
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic               mode_reg,    mode_next;
    logic               pend_reg,    pend_next;
    logic [3:0]         prev_reg,    prev_next;
    logic [1:0]         cidx_reg,    cidx_next;
    logic [TICK_W-1:0]  idle_reg,    idle_next;
    logic               beep_reg,    beep_next;

    // commit stream
    logic [COUNT_W-1:0] ccount_reg,  ccount_next;
    logic [COUNT_W-1:0] lim_reg,     lim_next;
    logic [COUNT_W-1:0] ci_reg,      ci_next;

    // result register
    logic      res_valid_reg;
    out_item_t res_reg;

    // buffer port signals
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    // helpers
    logic [COUNT_W-1:0] lim;
    logic [COUNT_W-1:0] count_m1;
    logic               room;
    logic [TICK_W-1:0]  idle_inc;
    logic [2:0]         cidx_inc;
    logic [1:0]         cidx_wrap;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
            timeout_reg    <= TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_MAX_LENGTH)
            begin
                max_length_reg <= wr_data[COUNT_W-1:0];
            end
            else if (wr_index == REG_TIMEOUT)
            begin
                timeout_reg <= wr_data[TICK_W-1:0];
            end
        end
    end

    // capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            op_reg  <= item.opcode;
            key_reg <= item.key_code;
        end
    end

    // effective limit, clamped to one up to the buffer capacity or COMMIT_MAX, whichever is smaller
    assign lim = (max_length_reg == '0) ? COUNT_W'(1)
               : ((max_length_reg > CAP_C) ? CAP_C : max_length_reg);
    assign count_m1  = count_reg - COUNT_W'(1);
    assign room      = (count_reg < lim);
    assign idle_inc  = (idle_reg != TICK_SAT) ? idle_reg + TICK_W'(1) : idle_reg;
    assign cidx_inc  = {1'b0, cidx_reg} + 3'd1;
    assign cidx_wrap = (cidx_inc == grp_size(key_reg)) ? 2'd0 : cidx_inc[1:0];

    // request execution
    always_comb
    begin
        count_next  = count_reg;
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        prev_next   = prev_reg;
        cidx_next   = cidx_reg;
        idle_next   = idle_reg;
        beep_next   = beep_reg;
        ccount_next = ccount_reg;
        lim_next    = lim_reg;
        ci_next     = ci_reg;
        we          = 1'b0;
        waddr       = AW'(count_reg);
        wdata       = EMPTY_CHAR;

        if (cmd.exec)
        begin
            beep_next = 1'b0;
            if (op_reg == OP_TICK)
            begin
                // timer tick ages a pending letter
                if (pend_reg)
                begin
                    idle_next = idle_inc;
                    if (idle_inc >= timeout_reg)
                    begin
                        pend_next = 1'b0;
                        cidx_next = 2'd0;
                        idle_next = '0;
                    end
                end
            end
            else if (key_reg == KEY_ENTER)
            begin
                // commit: keep count and limit for the stream, clear the entry
                ccount_next = count_reg;
                lim_next    = lim;
                ci_next     = '0;
                count_next  = '0;
                mode_next   = 1'b0;
                prev_next   = KEY_ZERO;
                pend_next   = 1'b0;
                cidx_next   = 2'd0;
                idle_next   = '0;
            end
            else if (key_reg == KEY_MODE)
            begin
                pend_next = 1'b0;
                cidx_next = 2'd0;
                idle_next = '0;
                mode_next = !mode_reg;
            end
            else if (key_reg == KEY_SPACE)
            begin
                pend_next = 1'b0;
                cidx_next = 2'd0;
                idle_next = '0;
                if (room)
                begin
                    we         = 1'b1;
                    wdata      = SPACE_CHAR;
                    count_next = count_reg + COUNT_W'(1);
                end
                else
                begin
                    beep_next = 1'b1;
                end
            end
            else if (key_reg == KEY_DELETE)
            begin
                pend_next = 1'b0;
                cidx_next = 2'd0;
                idle_next = '0;
                if (count_reg == '0)
                begin
                    beep_next = 1'b1;
                end
                else
                begin
                    count_next = count_m1;
                end
            end
            else if (key_reg inside {[KEY_ZERO:KEY_NINE]})
            begin
                if (!mode_reg)
                begin
                    // numeric mode appends the digit value
                    pend_next = 1'b0;
                    cidx_next = 2'd0;
                    idle_next = '0;
                    if (room)
                    begin
                        we         = 1'b1;
                        wdata      = {4'd0, key_reg};
                        count_next = count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        beep_next = 1'b1;
                    end
                end
                else if (key_reg != KEY_ZERO)
                begin
                    if (pend_reg && (prev_reg == key_reg) && (count_reg != '0))
                    begin
                        // same key again: cycle the last letter in place
                        cidx_next = cidx_wrap;
                        we        = 1'b1;
                        waddr     = AW'(count_m1);
                        wdata     = grp_sym(key_reg, cidx_wrap);
                        idle_next = '0;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        cidx_next = 2'd0;
                        idle_next = '0;
                        if (room)
                        begin
                            we         = 1'b1;
                            wdata      = grp_sym(key_reg, 2'd0);
                            count_next = count_reg + COUNT_W'(1);
                            pend_next  = 1'b1;
                            prev_next  = key_reg;
                        end
                        else
                        begin
                            beep_next = 1'b1;
                        end
                    end
                end
            end
        end

        if (cmd.emit_char)
        begin
            ci_next = ci_reg + COUNT_W'(1);
        end
    end

    // entry state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            mode_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            prev_reg   <= KEY_ZERO;
            cidx_reg   <= 2'd0;
            idle_reg   <= '0;
            beep_reg   <= 1'b0;
            ccount_reg <= '0;
            lim_reg    <= '0;
            ci_reg     <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            prev_reg   <= prev_next;
            cidx_reg   <= cidx_next;
            idle_reg   <= idle_next;
            beep_reg   <= beep_next;
            ccount_reg <= ccount_next;
            lim_reg    <= lim_next;
            ci_reg     <= ci_next;
        end
    end

    // buffer read: last character for status, stream index for commit
    assign re    = cmd.rd_stat || cmd.rd_char;
    assign raddr = cmd.rd_char ? AW'(ci_reg) : AW'(count_m1);

    mtte_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_CHARS)
    ) u_buf (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // result register; entries at or past the fill count read as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit_stat || cmd.emit_char)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_stat)
        begin
            res_reg.kind       <= KIND_STATUS;
            res_reg.char_value <= (count_reg == '0) ? EMPTY_CHAR : rdata;
            res_reg.position   <= (count_reg == '0) ? 5'd0 : count_m1[4:0];
            res_reg.length     <= count_reg;
            res_reg.alpha_mode <= mode_reg;
            res_reg.pending    <= pend_reg;
            res_reg.beep       <= beep_reg;
            res_reg.last       <= 1'b1;
        end
        else if (cmd.emit_char)
        begin
            res_reg.kind       <= KIND_CHAR;
            res_reg.char_value <= (ci_reg < ccount_reg) ? rdata : EMPTY_CHAR;
            res_reg.position   <= ci_reg[4:0];
            res_reg.length     <= count_reg;
            res_reg.alpha_mode <= mode_reg;
            res_reg.pending    <= pend_reg;
            res_reg.beep       <= 1'b0;
            res_reg.last       <= sts.final_char;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // status to the controller
    assign sts.is_commit  = (op_reg == OP_KEY) && (key_reg == KEY_ENTER);
    assign sts.final_char = ((ci_reg + COUNT_W'(1)) == lim_reg);
    assign sts.out_free   = !res_valid_reg || result_ready;

endmodule
`default_nettype wire

// ===== rtl/multi_tap_text_entry_top.sv =====
// ---------------------------------------------------------------------------
// multi_tap_text_entry_top: multi-tap keypad text entry
// Key and tick requests pass S_EXEC, S_RD and S_STAT into the result register;
// the next request is taken after that register is loaded.
// Commit: per character, a buffer RAM read (S_CRD) and an emit (S_CEMIT).
// Reset (rst_n, async): control state and registers cleared at once; buffer
// contents are masked by the fill count, so no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multi_tap_text_entry_top_macros.svh"

module multi_tap_text_entry_top
    import mtte_pkg::*;
#(
    parameter int BUFFER_CHARS = BUFFER_CHARS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire in_item_t               item,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output out_item_t                   result,
    input  wire logic                   wr_en,
    input  wire logic [REG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer
    mtte_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    // datapath
    mtte_dp #(
        .BUFFER_CHARS (BUFFER_CHARS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // one request in flight at a time
    `MTTE_ASSERT_NXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "request accepted while busy")
    // a status result always closes its request
    `MTTE_ASSERT_IMP(a_status_last, result_valid && (result.kind == KIND_STATUS), result.last, "status result without last")
    // committed characters show the cleared entry and never beep
    `MTTE_ASSERT_IMP(a_commit_clear, result_valid && (result.kind == KIND_CHAR), (result.length == '0) && !result.alpha_mode && !result.pending && !result.beep, "commit result not cleared")
    // fill count never passes the commit limit
    `MTTE_ASSERT_IMP(a_length_bound, result_valid, result.length <= COUNT_W'(COMMIT_MAX), "length out of range")

endmodule
`default_nettype wire

// ===== tb/sv/multi_tap_text_entry_top_test.sv =====
// ---------------------------------------------------------------------------
// multi_tap_text_entry_top_test
// Self-checking bench for the multi-tap keypad text entry block. A driver
// and a monitor, both clocked, move key and tick requests in and status or
// committed characters out. A built-in predictor of the entry buffer works
// out every expected result, and the monitor checks each one field by field.
// The run covers a directed sequence and then random key sequences over
// several register settings, most of them under random stalls on both sides.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_tap_text_entry_top_test;
    import mtte_pkg::*;

    localparam int ENTRY_CAP     = (BUFFER_CHARS_DEF < COMMIT_MAX) ? BUFFER_CHARS_DEF
                                                                   : COMMIT_MAX;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 5000;
    localparam int PRINT_LIMIT   = 40;
    localparam logic [3:0] KEY_SPARE_A = 4'd14;
    localparam logic [3:0] KEY_SPARE_B = 4'd15;

    // clock, reset and block ports
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    in_item_t               item         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    out_item_t              result;
    logic                   wr_en        = 1'b0;
    logic [REG_INDEX_W-1:0] wr_index     = '0;
    logic [CFG_DATA_W-1:0]  wr_data      = '0;

    // stall rates in percent
    int gap_pct   = 0;
    int stall_pct = 0;

    // requests waiting for the driver, results waiting for the monitor
    in_item_t  pending_reqs [$];
    out_item_t keypad_out_q [$];

    // predictor state and register copies
    logic [7:0]  entry_text [0:BUFFER_CHARS_DEF-1];
    logic [5:0]  entry_len;
    logic        alpha_on;
    logic        cycling;
    logic [3:0]  last_key;
    logic [1:0]  cycle_pos;
    logic [15:0] idle_count;
    logic [5:0]  cfg_max_length;
    logic [15:0] cfg_timeout;

    // run statistics
    int mismatches  = 0;
    int n_requests  = 0;
    int n_results   = 0;
    int n_chars     = 0;
    int n_beeps     = 0;
    int n_commits   = 0;
    int stall_count = 0;

    multi_tap_text_entry_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always #10 clk = ~clk;

    // symbols of each letter group
    function automatic string key_letters(input logic [3:0] key);
        case (key)
            4'd1:    return ".-";
            4'd2:    return "ABC";
            4'd3:    return "DEF";
            4'd4:    return "GHI";
            4'd5:    return "JKL";
            4'd6:    return "MNO";
            4'd7:    return "PQRS";
            4'd8:    return "TUV";
            4'd9:    return "WXYZ";
            default: return "";
        endcase
    endfunction

    // effective length limit, zero acts as one
    function automatic int entry_limit();
        int lim;
        lim = cfg_max_length;
        if (lim < 1)
            lim = 1;
        if (lim > ENTRY_CAP)
            lim = ENTRY_CAP;
        return lim;
    endfunction

    function automatic void fix_letter();
        cycling    = 1'b0;
        cycle_pos  = '0;
        idle_count = '0;
    endfunction

    function automatic void clear_entry();
        foreach (entry_text[i])
            entry_text[i] = EMPTY_CHAR;
        entry_len = '0;
        alpha_on  = 1'b0;
        last_key  = '0;
        fix_letter();
    endfunction

    // returns 1 when the character went in
    function automatic bit append_char(input logic [7:0] c);
        if (entry_len >= entry_limit() || entry_len >= BUFFER_CHARS_DEF)
            return 1'b0;
        entry_text[entry_len] = c;
        entry_len = entry_len + 6'd1;
        return 1'b1;
    endfunction

    // predicted results of one accepted request
    task automatic keypad_step(input in_item_t req);
        logic       beep_flag;
        int         lim;
        string      letters;
        out_item_t  r;
        logic [7:0] snap [0:BUFFER_CHARS_DEF-1];
        beep_flag = 1'b0;
        lim       = entry_limit();
        if (req.opcode == OP_TICK) begin
            if (cycling) begin
                if (idle_count != TICK_SAT)
                    idle_count = idle_count + 16'd1;
                if (idle_count >= cfg_timeout)
                    fix_letter();
            end
        end else if (req.key_code == KEY_ENTER) begin
            // commit streams the limit, unused slots read as empty
            snap = entry_text;
            clear_entry();
            for (int i = 0; i < lim; i++) begin
                r            = '0;
                r.kind       = KIND_CHAR;
                r.char_value = snap[i];
                r.position   = 5'(i);
                r.last       = (i == lim - 1);
                keypad_out_q.push_back(r);
            end
            n_commits++;
            return;
        end else if (req.key_code == KEY_MODE) begin
            fix_letter();
            alpha_on = ~alpha_on;
        end else if (req.key_code == KEY_SPACE) begin
            fix_letter();
            beep_flag = !append_char(SPACE_CHAR);
        end else if (req.key_code == KEY_DELETE) begin
            fix_letter();
            if (entry_len == 0) begin
                beep_flag = 1'b1;
            end else begin
                entry_len = entry_len - 6'd1;
                entry_text[entry_len] = EMPTY_CHAR;
            end
        end else if (req.key_code <= KEY_NINE) begin
            if (!alpha_on) begin
                fix_letter();
                beep_flag = !append_char({4'd0, req.key_code});
            end else if (req.key_code != KEY_ZERO) begin
                letters = key_letters(req.key_code);
                if (cycling && last_key == req.key_code && entry_len > 0) begin
                    // same key again: step through the group in place
                    cycle_pos = 2'((cycle_pos + 1) % letters.len());
                    entry_text[entry_len - 1] = letters[cycle_pos];
                    idle_count = '0;
                end else begin
                    fix_letter();
                    if (append_char(letters[0])) begin
                        cycling  = 1'b1;
                        last_key = req.key_code;
                    end else begin
                        beep_flag = 1'b1;
                    end
                end
            end
        end

        // status after the request
        r            = '0;
        r.kind       = KIND_STATUS;
        r.char_value = (entry_len > 0) ? entry_text[entry_len - 1] : EMPTY_CHAR;
        r.position   = (entry_len > 0) ? 5'(entry_len - 1) : 5'd0;
        r.length     = entry_len;
        r.alpha_mode = alpha_on;
        r.pending    = cycling;
        r.beep       = beep_flag;
        r.last       = 1'b1;
        keypad_out_q.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                      n_results, name, got, want));
    endtask

    // driver: holds each request until it is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            item_valid <= 1'b0;
        end else begin
            if (item_valid && item_ready) begin
                keypad_step(item);
                n_requests++;
            end
            if (!item_valid || item_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    item       <= pending_reqs.pop_front();
                    item_valid <= 1'b1;
                end else begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result against the oldest prediction
    always @(posedge clk) begin
        out_item_t want;
        if (!rst_n) begin
            result_ready <= 1'b0;
        end else begin
            if (result_valid && result_ready) begin
                if (keypad_out_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none predicted",
                                              n_results));
                end else begin
                    want = keypad_out_q.pop_front();
                    compare_field("kind", 8'(result.kind), 8'(want.kind));
                    compare_field("char_value", result.char_value, want.char_value);
                    compare_field("position", 8'(result.position), 8'(want.position));
                    compare_field("length", 8'(result.length), 8'(want.length));
                    compare_field("alpha_mode", 8'(result.alpha_mode), 8'(want.alpha_mode));
                    compare_field("pending", 8'(result.pending), 8'(want.pending));
                    compare_field("beep", 8'(result.beep), 8'(want.beep));
                    compare_field("last", 8'(result.last), 8'(want.last));
                end
                if (result.kind == KIND_CHAR)
                    n_chars++;
                if (result.beep === 1'b1)
                    n_beeps++;
                n_results++;
            end
            result_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic add_request(input logic op, input logic [3:0] key);
        in_item_t req;
        req.opcode   = op;
        req.key_code = key;
        pending_reqs.push_back(req);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic [REG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        if (idx == REG_MAX_LENGTH)
            cfg_max_length = data[5:0];
        else
            cfg_timeout = data;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || item_valid || keypad_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic start_phase(input logic [15:0] max_len, input logic [15:0] ticks,
                               input int gap, input int stall);
        wait_drained();
        write_reg(REG_MAX_LENGTH, max_len);
        write_reg(REG_TIMEOUT, ticks);
        gap_pct   <= gap;
        stall_pct <= stall;
    endtask

    // random key sequences, mostly well formed
    task automatic queue_random(input int n);
        int made;
        int pick;
        int reps;
        logic [3:0] key;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // one key pressed several times, ticks in between now and then
                key  = 4'($urandom_range(1, 9));
                reps = $urandom_range(1, 5);
                for (int i = 0; i < reps; i++) begin
                    add_request(OP_KEY, key);
                    made++;
                    if ($urandom_range(0, 3) == 0) begin
                        add_request(OP_TICK, 4'($urandom_range(0, 15)));
                        made++;
                    end
                end
            end else if (pick < 50) begin
                reps = $urandom_range(1, 4);
                for (int i = 0; i < reps; i++)
                    add_request(OP_TICK, 4'($urandom_range(0, 15)));
                made += reps;
            end else if (pick < 58) begin
                add_request(OP_KEY, KEY_MODE);
                made++;
            end else if (pick < 66) begin
                add_request(OP_KEY, KEY_SPACE);
                made++;
            end else if (pick < 76) begin
                add_request(OP_KEY, KEY_DELETE);
                made++;
            end else if (pick < 83) begin
                add_request(OP_KEY, KEY_ENTER);
                made++;
            end else if (pick < 90) begin
                add_request(OP_KEY, KEY_ZERO);
                made++;
            end else if (pick < 95) begin
                add_request(OP_KEY, ($urandom_range(0, 1) == 0) ? KEY_SPARE_A : KEY_SPARE_B);
                made++;
            end else begin
                add_request(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
                made++;
            end
        end
    endtask

    // stimulus
    initial begin
        clear_entry();
        cfg_max_length = MAX_LENGTH_RST;
        cfg_timeout    = TIMEOUT_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset registers, fill to the limit and commit
        gap_pct   <= 38;
        stall_pct <= 77;
        add_request(OP_KEY, KEY_DELETE);
        add_request(OP_KEY, KEY_ZERO);
        add_request(OP_KEY, KEY_NINE);
        add_request(OP_KEY, KEY_MODE);
        repeat (5) add_request(OP_KEY, 4'd7);
        repeat (4) add_request(OP_KEY, 4'd8);
        add_request(OP_KEY, KEY_ZERO);
        add_request(OP_KEY, 4'd1);
        add_request(OP_TICK, KEY_SPARE_B);
        add_request(OP_KEY, KEY_SPACE);
        add_request(OP_KEY, 4'd1);
        add_request(OP_KEY, KEY_DELETE);
        repeat (5) add_request(OP_KEY, KEY_SPACE);
        add_request(OP_KEY, KEY_SPARE_B);
        add_request(OP_KEY, KEY_ENTER);

        // widest limit written with stray upper bits, short timeout
        start_phase(16'hFFE0, 16'd3, 38, 77);
        queue_random(40);

        // zero limit and zero timeout
        start_phase(16'd0, 16'd0, 77, 38);
        queue_random(30);

        // oversized limit clamps, leave many characters behind
        start_phase(16'd63, 16'd1, 77, 38);
        queue_random(35);
        repeat (12) add_request(OP_KEY, KEY_SPACE);

        // limit shrunk below the count, longest timeout
        start_phase(16'd3, 16'hFFFF, 0, 0);
        add_request(OP_KEY, KEY_SPACE);
        add_request(OP_KEY, 4'd2);
        add_request(OP_KEY, KEY_ENTER);
        queue_random(30);

        start_phase(16'd17, 16'd2, 0, 0);
        queue_random(40);

        wait_drained();
        if (keypad_out_q.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      keypad_out_q.size()));
        $display("covered %0d requests and %0d results over six register settings",
                 n_requests, n_results);
        $display("  %0d commits, %0d committed characters, %0d refused actions",
                 n_commits, n_chars, n_beeps);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
